// ----- rtl/smtprp_pkg.sv -----
// ----------------------------------------------------------------------------
// smtprp_pkg
// Types and character constants shared by the reply-code parser modules.
// ----------------------------------------------------------------------------
package smtprp_pkg;

    // Characters that the line check recognizes.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Width of a reply code and of the expected-code register.
    localparam int CODE_W = 10;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_LINK       = 3'd1,
        ST_MALFORMED  = 3'd2,
        ST_DELIM      = 3'd3,
        ST_TOO_LONG   = 3'd4,
        ST_UNEXPECTED = 3'd5
    } status_t;

    // One received word.
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       link_closed;
    } reply_in_t;

    // One result word.
    typedef struct packed {
        logic [CODE_W-1:0] smtp_code;
        status_t           status;
    } reply_out_t;

    // Handshake control from the line check to the register stages.
    typedef struct packed {
        logic take;   // the held input word is consumed this cycle
        logic load;   // a result word is written to the output register
    } chk_ctrl_t;

endpackage

// ----- rtl/smtp_reply_parser.sv -----
// A byte waits in the input register and its result word in the output register.
// Throughput: one byte per cycle unless the input stalls; the line state updates as each byte is taken.
// Input stalls only while a result waits in the output register and the held
// byte would produce another one.
// Reset (aresetn low, synchronous) empties both registers, zeroes the line
// position and sets the expected code to zero.
// ----------------------------------------------------------------------------
// smtp_reply_parser
// Parses server reply bytes into a three-digit reply code and a status word.
// ----------------------------------------------------------------------------
module smtp_reply_parser
    import smtprp_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 512
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CODE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  reply_in_t         s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output reply_out_t        m_item
);

    logic [CODE_W-1:0] match_code_reg;
    logic              in_valid;
    reply_in_t         in_item;
    logic              out_free;
    chk_ctrl_t         ctrl;
    reply_out_t        res_item;

    // Expected-code register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_code_reg <= '0;
        end else if (cfg_valid) begin
            match_code_reg <= cfg_data;
        end
    end

    smtprp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .take     (ctrl.take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    smtprp_line_check #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_line_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .match_code (match_code_reg),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .res_item   (res_item)
    );

    smtprp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctrl.load),
        .res_item (res_item),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // Error results other than an unexpected code carry a zero code.
    a_err_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == ST_LINK || m_item.status == ST_MALFORMED ||
                    m_item.status == ST_DELIM || m_item.status == ST_TOO_LONG)
        |-> m_item.smtp_code == '0)
        else $error("error result with nonzero code");

    // A reported code is always three decimal digits.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.smtp_code <= CODE_W'(999))
        else $error("reply code out of range");

    // An empty input register always admits a new byte.
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |-> s_ready)
        else $error("input stalled while empty");

endmodule

// ----- rtl/smtprp_in_reg.sv -----
// ----------------------------------------------------------------------------
// smtprp_in_reg
// Input register stage: holds one received word until the line check takes it.
// ----------------------------------------------------------------------------
module smtprp_in_reg
    import smtprp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  reply_in_t s_item,
    input  logic      take,
    output logic      in_valid,
    output reply_in_t in_item
);

    logic      valid_reg;
    logic      valid_next;
    reply_in_t item_reg;

    // A new word may enter when the register is empty or is being drained.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

// ----- rtl/smtprp_line_check.sv -----
// ----------------------------------------------------------------------------
// smtprp_line_check
// Line state and per-word check: tracks position and header of the current line,
// checks completed, overlong and link-closed lines; at most one result per word.
// ----------------------------------------------------------------------------
module smtprp_line_check
    import smtprp_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 512
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  reply_in_t         in_item,
    input  logic [CODE_W-1:0] match_code,
    input  logic              out_free,
    output chk_ctrl_t         ctrl,
    output reply_out_t        res_item
);

    localparam int PW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_BUFFER_SIZE - 1);
    localparam logic [PW-1:0] HDR_LEN   = PW'(4);

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_inc;
    logic [7:0]    hdr_reg [4];
    logic [7:0]    hdr_next [4];
    logic [7:0]    c;
    logic          emit;
    logic          clear;
    logic          digits_ok;
    logic [CODE_W-1:0] code;
    reply_out_t    res;

    assign c       = in_item.reply_byte;
    assign pos_inc = pos_reg + PW'(1);

    // Header as it stands after this byte: the byte lands at its position
    // while the line is still within its first four bytes.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            hdr_next[i] = (pos_reg == PW'(i)) ? c : hdr_reg[i];
        end
    end

    // Digit check and decimal value of the three code bytes.
    always_comb begin
        digits_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (hdr_next[i] < CH_ZERO || hdr_next[i] > CH_NINE) begin
                digits_ok = 1'b0;
            end
        end
        code = CODE_W'(hdr_next[0][3:0]) * CODE_W'(100)
             + CODE_W'(hdr_next[1][3:0]) * CODE_W'(10)
             + CODE_W'(hdr_next[2][3:0]);
    end

    // Per-word decision.
    always_comb begin
        emit          = 1'b0;
        clear         = 1'b0;
        res.smtp_code = '0;
        res.status    = ST_OK;
        if (in_item.link_closed) begin
            emit       = 1'b1;
            clear      = 1'b1;
            res.status = ST_LINK;
        end else if (c == CH_NEWLINE) begin
            clear = 1'b1;
            if (pos_inc < HDR_LEN || !digits_ok) begin
                emit       = 1'b1;
                res.status = ST_MALFORMED;
            end else if (hdr_next[3] == CH_DASH) begin
                emit = 1'b0;
            end else if (hdr_next[3] != CH_SPACE) begin
                emit       = 1'b1;
                res.status = ST_DELIM;
            end else if (match_code != '0 && code != match_code) begin
                emit          = 1'b1;
                res.smtp_code = code;
                res.status    = ST_UNEXPECTED;
            end else begin
                emit          = 1'b1;
                res.smtp_code = code;
                res.status    = ST_OK;
            end
        end else if (pos_inc >= POS_LIMIT) begin
            emit       = 1'b1;
            clear      = 1'b1;
            res.status = ST_TOO_LONG;
        end
        pos_next = clear ? '0 : pos_inc;
    end

    // A word is taken unless its result has nowhere to go.
    assign ctrl.take = in_valid && (!emit || out_free);
    assign ctrl.load = ctrl.take && emit;
    assign res_item  = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (ctrl.take) begin
            pos_reg <= pos_next;
        end
    end

    // Header bytes are always rewritten before a newline reads them.
    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            for (int i = 0; i < 4; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    // The position never reaches the too-long limit in the register.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_LIMIT)
        else $error("line position reached the limit");

    // A closed link always clears the line position.
    a_link_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.take && in_item.link_closed |=> pos_reg == '0)
        else $error("link closure did not clear the line");

    // No word is consumed with a result while the output is occupied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> out_free)
        else $error("result loaded into a busy output register");

endmodule

// ----- rtl/smtprp_out_reg.sv -----
// ----------------------------------------------------------------------------
// smtprp_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module smtprp_out_reg
    import smtprp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  reply_out_t res_item,
    output logic       out_free,
    output logic       m_valid,
    input  logic       m_ready,
    output reply_out_t m_item
);

    logic       valid_reg;
    logic       valid_next;
    reply_out_t item_reg;

    // The register is free when empty or when its word leaves this cycle.
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= res_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule
